/* hw/rtl/sfw_pkg.sv */
package sfw_pkg;

  // Field widths of the command and of one serial bit beat.
  localparam int AddrW  = 4;
  localparam int DataW  = 20;
  localparam int FreqW  = 32;
  localparam int IdxW   = 5;
  localparam int FrameW = 25;

  // Command codes.
  localparam logic CmdRaw  = 1'b0;
  localparam logic CmdFreq = 1'b1;

  // Register that holds the N/A divider pair.
  localparam logic [AddrW-1:0] FreqReg = 4'd1;

  // Index of the write flag in the frame, and of the last bit.
  localparam logic [IdxW-1:0] WriteFlagIdx = 5'd4;
  localparam logic [IdxW-1:0] LastIdx      = 5'd24;

  // The channel step is 20000 = 32 * 625. The factor 32 is a shift. The factor
  // 625 is a multiply by floor(2^37 / 625), which is low by at most one.
  localparam int ChanShift  = 5;
  localparam int DivInW     = FreqW - ChanShift;   // 27 bits
  localparam int RecipW     = 28;
  localparam logic [RecipW-1:0] Recip625 = 28'd219902325;
  localparam int RecipShift = 37;
  localparam int ProdW      = DivInW + RecipW;     // 55 bits
  localparam int QuotW      = 18;                  // f / 20000 < 2^18
  localparam int RemW       = 11;                  // estimate remainder < 1250
  localparam logic [9:0]      Div625  = 10'd625;
  localparam logic [RemW-1:0] Rem625  = 11'd625;

endpackage

/* hw/rtl/sfw_if.sv */
// Command channel: one beat is one write or frequency set.
interface sfw_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sfw_pkg::AddrW-1:0]   reg_addr;
  logic [sfw_pkg::DataW-1:0]   reg_data;
  logic [sfw_pkg::FreqW-1:0]   half_frequency;

  modport source (output valid, cmd, reg_addr, reg_data, half_frequency, input ready);
  modport sink   (input valid, cmd, reg_addr, reg_data, half_frequency, output ready);
endinterface

// Serial bit channel: one beat is one bit slot of the frame.
interface sfw_bit_if;
  logic                      valid;
  logic                      ready;
  logic                      serial_bit;
  logic [sfw_pkg::IdxW-1:0]  bit_index;
  logic                      frame_last;

  modport source (output valid, serial_bit, bit_index, frame_last, input ready);
  modport sink   (input valid, serial_bit, bit_index, frame_last, output ready);
endinterface

/* hw/rtl/synth_frequency_serial_writer.sv */
// Serial frame writer for a PLL synthesizer with an N/A divider pair.
//
// The command channel takes one beat per command. A raw write (cmd = 0) sends
// reg_data to reg_addr. A frequency set (cmd = 1) takes half the wanted
// frequency in hertz, forms N = f / 1280000 and A = (f / 20000) mod 64, and
// writes A | N << 7 to register 1. Each command yields one 25-bit frame on the
// bit channel, LSB first: address in bits 0-3, write flag in bit 4, data in
// bits 5-24. frame_last marks bit 24.
//
// A command passes through three pipeline stages (reciprocal multiply,
// remainder check, frame build) into a shift register, which sends one bit
// per cycle while the receiver accepts them. Commands are taken while a frame
// is still shifting, up to three waiting in the stages behind it.
//
// When the receiver stalls, the current bit beat holds and the stages fill
// up; command ready drops once all of them hold an item. Reset clears all
// valid bits and the shift register; no frame is in progress after it.
module synth_frequency_serial_writer (
  input  logic         clk,
  input  logic         rst,
  sfw_cmd_if.sink      command,
  sfw_bit_if.source    frame_bit
);
  import sfw_pkg::*;

  // Stage 1: divide by 32 with a shift and estimate the quotient by 625.
  logic              v1;
  logic              cmd1;
  logic [AddrW-1:0]  addr1;
  logic [DataW-1:0]  data1;
  logic [DivInW-1:0] x1;
  logic [QuotW-1:0]  qe1;

  // Stage 2: remainder of the estimate.
  logic              v2;
  logic              cmd2;
  logic [AddrW-1:0]  addr2;
  logic [DataW-1:0]  data2;
  logic [QuotW-1:0]  qe2;
  logic [RemW-1:0]   rem2;

  // Stage 3: finished frame.
  logic              v3;
  logic [FrameW-1:0] frame3;

  // Shift register.
  logic              busy;
  logic [FrameW-1:0] shreg;
  logic [IdxW-1:0]   idx;

  logic              ready1;
  logic              ready2;
  logic              ready3;
  logic              load_ser;
  logic              out_fire;
  logic              out_last;

  logic [DivInW-1:0] x_in;
  logic [ProdW-1:0]  prod1;
  logic [27:0]       back2;
  logic [27:0]       diff2;
  logic [QuotW-1:0]  q3;
  logic [DataW-1:0]  word3;
  logic [DataW-1:0]  data3;
  logic [AddrW-1:0]  addr3;

  // Flow control: a stage moves on when the one after it has room.
  assign out_fire = frame_bit.valid && frame_bit.ready;
  assign out_last = idx == LastIdx;
  assign load_ser = !busy || (out_fire && out_last);
  assign ready3   = !v3 || load_ser;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign command.ready = ready1;

  // Reciprocal multiply for the quotient estimate.
  assign x_in  = command.half_frequency[FreqW-1:ChanShift];
  assign prod1 = {{RecipW{1'b0}}, x_in} * {{DivInW{1'b0}}, Recip625};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= command.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      cmd1  <= command.cmd;
      addr1 <= command.reg_addr;
      data1 <= command.reg_data;
      x1    <= x_in;
      qe1   <= prod1[RecipShift +: QuotW];
    end
  end

  // Remainder of the estimate; it lies below twice the divisor.
  assign back2 = {{(28-QuotW){1'b0}}, qe1} * {18'd0, Div625};
  assign diff2 = {1'b0, x1} - back2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      cmd2  <= cmd1;
      addr2 <= addr1;
      data2 <= data1;
      qe2   <= qe1;
      rem2  <= diff2[RemW-1:0];
    end
  end

  // Correct the quotient, split it into N and A, and frame the word.
  assign q3    = qe2 + {{(QuotW-1){1'b0}}, (rem2 >= Rem625)};
  assign word3 = {1'b0, q3[QuotW-1:6], 1'b0, q3[5:0]};
  assign data3 = (cmd2 == CmdFreq) ? word3 : data2;
  assign addr3 = (cmd2 == CmdFreq) ? FreqReg : addr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      frame3 <= {data3, 1'b1, addr3};
    end
  end

  // Shift register sends one bit per accepted beat and reloads after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      shreg <= '0;
      idx   <= '0;
    end else if (load_ser) begin
      busy  <= v3;
      shreg <= frame3;
      idx   <= '0;
    end else if (out_fire) begin
      shreg <= {1'b0, shreg[FrameW-1:1]};
      idx   <= idx + 1'b1;
    end
  end

  assign frame_bit.valid      = busy;
  assign frame_bit.serial_bit = shreg[0];
  assign frame_bit.bit_index  = idx;
  assign frame_bit.frame_last = out_last;

  // A bit beat taken before the last is followed by the next position.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_last |=> frame_bit.valid && idx == $past(idx) + 1'b1)
    else $error("bit index did not advance by one");

  // The write flag position always carries a one.
  a_write_flag: assert property (@(posedge clk) disable iff (rst)
    busy && idx == WriteFlagIdx |-> shreg[0])
    else $error("write flag missing from frame");

  // The estimated quotient is never more than one below the true one.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> rem2 < (Rem625 + Rem625))
    else $error("quotient estimate off by more than one");

  // An accepted command always lands in the first stage.
  a_intake: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.ready |=> v1)
    else $error("accepted command lost at intake");

endmodule
